[src/rcec_pkg.sv]
// Shared types, constants and byte classification for the escape codec.
`timescale 1ns / 1ps

package rcec_pkg;

	// Marker and masks of the private-use three-byte sequence, and characters it escapes
	localparam logic [7:0] MARK_BYTE   = 8'hEF;
	localparam logic [7:0] CONT_BASE   = 8'h80;
	localparam logic [7:0] LEAD_MASK   = 8'hFC;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] LOW6_MASK   = 8'h3F;
	localparam logic [7:0] CTRL_LIMIT  = 8'h20;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;

	// Direction register values
	localparam logic DIR_ESCAPE   = 1'b0;
	localparam logic DIR_UNESCAPE = 1'b1;

	// Hold states of the unescape path
	localparam logic [1:0] HOLD_NONE = 2'd0;
	localparam logic [1:0] HOLD_MARK = 2'd1;
	localparam logic [1:0] HOLD_LEAD = 2'd2;

	// Register index of the configuration port
	localparam logic REG_DIRECTION = 1'b0;

	// Queue between front and back
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// One classified input: up to three output bytes
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] cnt;
		logic       last;
	} rcec_entry_t;

	// Queue status seen by the front and back parts
	typedef struct packed {
		logic full;
		logic empty;
	} rcec_qstat_t;

	function automatic logic is_special_byte(input logic [7:0] b);
		logic r;
		r = (b < CTRL_LIMIT);
		unique case (b)
			8'h3C, 8'h3E, 8'h3A, 8'h22, 8'h7C, 8'h3F, 8'h2A, 8'h5C: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

endpackage

[src/reserved_char_escape_codec.sv]
// Top level of the reserved-character escape codec with its register port.
//
// Codes a file-name component one byte per input transfer (in_byte, in_last
// on a valid/ready channel) into bytes on the output channel (out_byte,
// out_last). Register 0 at byte address 0 is direction: 0 escapes reserved
// bytes into EF 8x xx sequences, 1 unescapes such sequences back to bytes.
// Writing direction drops any held unescape bytes; write it only while idle.
// The first byte of an input is stored in a queue entry and then in the output
// register before it is presented. An escaped byte or a broken-off held
// sequence yields up to three bytes, which leave one by one through the
// one-byte-wide output register; an input that yields one byte needs only one
// output transfer. Held bytes produce no output until the sequence completes,
// breaks or ends with in_last.
// A two-entry queue separates input classification from output sequencing,
// so input keeps flowing until the queue fills while the receiver stalls;
// the output holds its byte steady until taken.
// Reset clears direction to escape, the hold state, queue and output valid.
`timescale 1ns / 1ps

module reserved_char_escape_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last
);

	logic direction_q;
	logic dir_wr;
	logic push;
	logic pop;
	rcec_pkg::rcec_entry_t push_entry;
	rcec_pkg::rcec_entry_t pop_entry;
	rcec_pkg::rcec_qstat_t qstat;

	// Decode register writes
	assign pready = 1'b1;
	assign dir_wr = psel && penable && pwrite && pready && (paddr[2] == rcec_pkg::REG_DIRECTION);
	assign prdata = (paddr[2] == rcec_pkg::REG_DIRECTION) ? {31'd0, direction_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= rcec_pkg::DIR_ESCAPE;
		end else if (dir_wr) begin
			direction_q <= pwdata[0];
		end
	end

	rcec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (direction_q),
		.hold_clear (dir_wr),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	rcec_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	rcec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_entry  (pop_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

[src/rcec_front.sv]
// Front part: accepts input bytes, tracks held sequences, builds queue entries.
`timescale 1ns / 1ps

module rcec_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                direction,
	input  logic                hold_clear,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  rcec_pkg::rcec_qstat_t qstat,
	output logic                push,
	output rcec_pkg::rcec_entry_t push_entry
);

	logic [1:0] held_count_q;
	logic [1:0] held_high_bits_q;
	logic [1:0] held_count_nxt;
	logic [1:0] held_high_bits_nxt;
	logic       accept;
	logic       is_mark;
	logic [7:0] lead_byte;
	rcec_pkg::rcec_entry_t ent;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign is_mark  = (in_byte == rcec_pkg::MARK_BYTE) && !in_last;
	assign lead_byte = rcec_pkg::CONT_BASE | {6'd0, held_high_bits_q};

	// Classify the byte and work out the bytes it releases
	always_comb begin
		ent = '0;
		ent.last = in_last;
		held_count_nxt = held_count_q;
		held_high_bits_nxt = held_high_bits_q;
		if (direction == rcec_pkg::DIR_ESCAPE) begin
			if (rcec_pkg::is_special_byte(in_byte) || (in_last &&
					(in_byte == rcec_pkg::CHAR_DOT || in_byte == rcec_pkg::CHAR_SPACE))) begin
				ent.b0 = rcec_pkg::MARK_BYTE;
				ent.b1 = rcec_pkg::CONT_BASE | {6'd0, in_byte[7:6]};
				ent.b2 = rcec_pkg::CONT_BASE | (in_byte & rcec_pkg::LOW6_MASK);
				ent.cnt = 2'd3;
			end else begin
				ent.b0 = in_byte;
				ent.cnt = 2'd1;
			end
		end else begin
			unique case (held_count_q)
				rcec_pkg::HOLD_MARK: begin
					if (((in_byte & rcec_pkg::LEAD_MASK) == rcec_pkg::CONT_BASE) && !in_last) begin
						held_count_nxt = rcec_pkg::HOLD_LEAD;
						held_high_bits_nxt = in_byte[1:0];
					end else if (is_mark) begin
						ent.b0 = rcec_pkg::MARK_BYTE;
						ent.cnt = 2'd1;
					end else begin
						ent.b0 = rcec_pkg::MARK_BYTE;
						ent.b1 = in_byte;
						ent.cnt = 2'd2;
						held_count_nxt = rcec_pkg::HOLD_NONE;
					end
				end
				rcec_pkg::HOLD_LEAD: begin
					held_high_bits_nxt = 2'd0;
					if ((in_byte & rcec_pkg::CONT_MASK) == rcec_pkg::CONT_BASE) begin
						ent.b0 = {held_high_bits_q, in_byte[5:0]};
						ent.cnt = 2'd1;
						held_count_nxt = rcec_pkg::HOLD_NONE;
					end else if (is_mark) begin
						ent.b0 = rcec_pkg::MARK_BYTE;
						ent.b1 = lead_byte;
						ent.cnt = 2'd2;
						held_count_nxt = rcec_pkg::HOLD_MARK;
					end else begin
						ent.b0 = rcec_pkg::MARK_BYTE;
						ent.b1 = lead_byte;
						ent.b2 = in_byte;
						ent.cnt = 2'd3;
						held_count_nxt = rcec_pkg::HOLD_NONE;
					end
				end
				default: begin
					if (is_mark) begin
						held_count_nxt = rcec_pkg::HOLD_MARK;
					end else begin
						ent.b0 = in_byte;
						ent.cnt = 2'd1;
					end
				end
			endcase
		end
	end

	assign push       = accept && (ent.cnt != 2'd0);
	assign push_entry = ent;

	// Advance the hold state on each transfer; drop it on a direction write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q <= rcec_pkg::HOLD_NONE;
			held_high_bits_q <= 2'd0;
		end else if (hold_clear) begin
			held_count_q <= rcec_pkg::HOLD_NONE;
			held_high_bits_q <= 2'd0;
		end else if (accept) begin
			held_count_q <= held_count_nxt;
			held_high_bits_q <= held_high_bits_nxt;
		end
	end

endmodule

[src/rcec_fifo.sv]
// Short queue of classified entries between the front and back parts.
`timescale 1ns / 1ps

module rcec_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rcec_pkg::rcec_entry_t push_entry,
	input  logic                  pop,
	output rcec_pkg::rcec_entry_t pop_entry,
	output rcec_pkg::rcec_qstat_t qstat
);

	rcec_pkg::rcec_entry_t mem_q [rcec_pkg::FIFO_DEPTH];
	logic [rcec_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [rcec_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [rcec_pkg::FIFO_CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	localparam logic [rcec_pkg::FIFO_PTR_W-1:0] PTR_LAST =
		rcec_pkg::FIFO_PTR_W'(rcec_pkg::FIFO_DEPTH - 1);
	localparam logic [rcec_pkg::FIFO_CNT_W-1:0] CNT_FULL =
		rcec_pkg::FIFO_CNT_W'(rcec_pkg::FIFO_DEPTH);
	localparam logic [rcec_pkg::FIFO_CNT_W-1:0] CNT_ONE =
		rcec_pkg::FIFO_CNT_W'(1);

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign do_push = push && !qstat.full;
	assign do_pop  = pop && !qstat.empty;
	assign pop_entry = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

endmodule

[src/rcec_back.sv]
// Back part: serializes queued entries into one output byte per transfer.
`timescale 1ns / 1ps

module rcec_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rcec_pkg::rcec_qstat_t qstat,
	input  rcec_pkg::rcec_entry_t pop_entry,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  out_last
);

	rcec_pkg::rcec_entry_t cur_q;
	logic [1:0] pos_q;
	logic       busy_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       adv;
	logic [7:0] cur_byte;

	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !busy_q && !qstat.empty;

	// Pick the next byte of the entry in progress
	always_comb begin
		unique case (pos_q)
			2'd2: cur_byte = cur_q.b2;
			2'd1: cur_byte = cur_q.b1;
			default: cur_byte = cur_q.b0;
		endcase
	end

	// Hold the entry in progress
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy_q) begin
				out_byte_q <= cur_byte;
				out_last_q <= cur_q.last && (pos_q == cur_q.cnt - 2'd1);
			end else begin
				out_byte_q <= pop_entry.b0;
				out_last_q <= pop_entry.last && (pop_entry.cnt == 2'd1);
			end
		end
	end

	// Advance position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			busy_q <= 1'b0;
			pos_q <= 2'd0;
		end else if (adv) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				pos_q <= pos_q + 2'd1;
				busy_q <= (pos_q != cur_q.cnt - 2'd1);
			end else if (!qstat.empty) begin
				out_valid_q <= 1'b1;
				pos_q <= 2'd1;
				busy_q <= (pop_entry.cnt != 2'd1);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule
